// ----- src/assert_macros.svh -----
// Assertion macros used by the allocation tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ATT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocation tracker: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ATT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocation tracker: next-cycle check failed");

`endif

// ----- src/att_pkg.sv -----
// Types and codes shared by the allocation tracker modules.
`default_nettype none

package att_pkg;

    localparam int ADDR_W     = 64;
    localparam int REPORT_CAP = 32;
    localparam int LEAK_CNT_W = $clog2(REPORT_CAP + 1);

    // Operation codes.
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    // Result status codes.
    localparam logic [3:0] ST_NULL_ALLOC   = 4'd0;
    localparam logic [3:0] ST_NEW          = 4'd1;
    localparam logic [3:0] ST_REVIVED      = 4'd2;
    localparam logic [3:0] ST_REALLOC_LIVE = 4'd3;
    localparam logic [3:0] ST_FULL         = 4'd4;
    localparam logic [3:0] ST_FREED        = 4'd5;
    localparam logic [3:0] ST_DOUBLE_FREE  = 4'd6;
    localparam logic [3:0] ST_UNKNOWN_FREE = 4'd7;
    localparam logic [3:0] ST_LEAK         = 4'd8;
    localparam logic [3:0] ST_NO_LEAK      = 4'd9;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
    } t_cmd;

    typedef struct packed {
        logic [3:0]        status;
        logic [ADDR_W-1:0] report_address;
        logic              last;
    } t_result;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic              freed;
        logic [ADDR_W-1:0] address;
    } t_entry;

endpackage

`default_nettype wire

// ----- src/att_entry_mem.sv -----
// Entry memory of the allocation tracker: one write port, one registered read port.
`default_nettype none

module att_entry_mem
    import att_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_idx,
    input  wire t_entry           i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    output t_entry                o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/allocation_tracker_table.sv -----
// Top level of the heap allocation tracker with double-free and leak detection.
`default_nettype none

// The block tracks up to TABLE_DEPTH heap addresses, each marked live or freed,
// and checks allocation, free and leak-report commands against that table.
// A command is transferred when start is high and busy is low. An allocation
// of the null address is answered in the following cycle and does not make
// the block busy. Every other allocation, every free and every report walks
// the whole table through the single read port of the entry memory, one entry
// per cycle, and such a command keeps busy high through the walk and its
// write-back, with its final result given at the end. Operation code 3 is
// ignored: it gives no result and leaves busy low. Each result is presented
// for exactly one cycle with o_strobe high; the receiver cannot hold results
// off, so it must take every result transfer as it comes. A report delivers
// all but the last of its leaked addresses while the walk is still in
// progress, in ascending entry order, with last set only on the final one,
// and at most REPORT_CAP of them; with no leak it gives a single no-leak
// result. The table is updated only at the end of a walk, and only one
// command is ever in flight, so a read never meets a pending write to the
// same entry.
module allocation_tracker_table
    import att_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_cmd    i_cmd,
    output logic         busy,
    output logic         o_strobe,
    output t_result      o_result
);

`include "assert_macros.svh"

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Control registers.
    logic [1:0]             r_state;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_rd_vld;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                   r_hit;
    logic                   r_have_free;
    logic                   r_pend;
    logic [LEAK_CNT_W-1:0]  r_leak_cnt;
    logic                   r_out_vld;

    // Payload registers.
    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_hit_freed;
    logic [IDX_W-1:0]  r_free_idx;
    logic [ADDR_W-1:0] r_pend_addr;
    t_result           r_out;

    t_entry            w_rd_data;
    logic              w_accept;
    logic              w_rd_entry_valid;
    logic              w_hit_now;
    logic              w_free_now;
    logic              w_leak_now;
    logic              w_emit_leak;

    // End-of-walk decision and write-back.
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_idx;
    t_entry            w_wr_data;
    logic              w_set_valid;
    t_result           w_fin_result;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    att_entry_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (w_wr_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (r_state == S_SCAN),
        .i_rd_idx  (r_idx),
        .o_rd_data (w_rd_data)
    );

    // The compare stage looks at the entry read in the previous cycle.
    // Valid bits only change at the end of a walk, so they line up with it.
    assign w_rd_entry_valid = r_valid[r_rd_idx];
    assign w_hit_now  = r_rd_vld && w_rd_entry_valid &&
                        (w_rd_data.address == r_cmd.address);
    assign w_free_now = r_rd_vld && !w_rd_entry_valid && !r_have_free;
    assign w_leak_now = r_rd_vld && (r_cmd.operation == OP_REPORT) &&
                        w_rd_entry_valid && !w_rd_data.freed &&
                        (r_leak_cnt < LEAK_CNT_W'(REPORT_CAP));
    // A held leak is released once another one shows that it is not the final one.
    assign w_emit_leak = w_leak_now && r_pend;

    always_comb begin
        w_wr_en      = 1'b0;
        w_wr_idx     = r_hit_idx;
        w_wr_data    = '{freed: 1'b0, address: r_cmd.address};
        w_set_valid  = 1'b0;
        w_fin_result = '{status: ST_NO_LEAK, report_address: '0, last: 1'b1};
        if (r_state == S_FINISH) begin
            case (r_cmd.operation)
                OP_ALLOC: begin
                    w_fin_result.report_address = r_cmd.address;
                    if (r_hit) begin
                        if (r_hit_freed) begin
                            w_fin_result.status = ST_REVIVED;
                            w_wr_en             = 1'b1;
                        end else begin
                            w_fin_result.status = ST_REALLOC_LIVE;
                        end
                    end else if (r_have_free) begin
                        w_fin_result.status = ST_NEW;
                        w_wr_en             = 1'b1;
                        w_wr_idx            = r_free_idx;
                        w_set_valid         = 1'b1;
                    end else begin
                        w_fin_result.status = ST_FULL;
                    end
                end
                OP_FREE: begin
                    w_fin_result.report_address = r_cmd.address;
                    if (!r_hit) begin
                        w_fin_result.status = ST_UNKNOWN_FREE;
                    end else if (r_hit_freed) begin
                        w_fin_result.status = ST_DOUBLE_FREE;
                    end else begin
                        w_fin_result.status = ST_FREED;
                        w_wr_en             = 1'b1;
                        w_wr_data.freed     = 1'b1;
                    end
                end
                OP_REPORT: begin
                    if (r_pend) begin
                        w_fin_result.status         = ST_LEAK;
                        w_fin_result.report_address = r_pend_addr;
                    end
                end
                default: begin
                    w_fin_result.status = ST_NO_LEAK;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_valid     <= '0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            r_pend      <= 1'b0;
            r_leak_cnt  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_rd_vld  <= (r_state == S_SCAN);
            // A result goes out for a released leak, at the end of a walk, or
            // straight after a null allocation.
            r_out_vld <= w_emit_leak || (r_state == S_FINISH) ||
                         (w_accept && (i_cmd.operation == OP_ALLOC) &&
                          (i_cmd.address == '0));
            if (w_hit_now) begin
                r_hit <= 1'b1;
            end
            if (w_free_now) begin
                r_have_free <= 1'b1;
            end
            if (w_leak_now) begin
                r_pend     <= 1'b1;
                r_leak_cnt <= r_leak_cnt + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_cmd.operation)
                            OP_ALLOC: begin
                                if (i_cmd.address != '0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_FREE, OP_REPORT: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                        r_idx       <= '0;
                        r_hit       <= 1'b0;
                        r_have_free <= 1'b0;
                        r_pend      <= 1'b0;
                        r_leak_cnt  <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_state <= S_IDLE;
                    if (w_set_valid) begin
                        r_valid[w_wr_idx] <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Command, compare results and output payload.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        if (w_hit_now) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_freed <= w_rd_data.freed;
        end
        if (w_free_now) begin
            r_free_idx <= r_rd_idx;
        end
        if (w_leak_now) begin
            r_pend_addr <= w_rd_data.address;
        end
        if (r_state == S_FINISH) begin
            r_out <= w_fin_result;
        end else if (w_emit_leak) begin
            r_out <= '{status: ST_LEAK, report_address: r_pend_addr, last: 1'b0};
        end else if (w_accept) begin
            r_out <= '{status: ST_NULL_ALLOC, report_address: '0, last: 1'b1};
        end
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    // The compare stage only carries data while the table is being walked.
    `ATT_ASSERT_IMP(a_rd_in_walk, i_clk, i_rst_n, r_rd_vld,
        (r_state == S_SCAN) || (r_state == S_DRAIN))
    // The end of a walk always produces the final result of the command.
    `ATT_ASSERT_NXT(a_finish_result, i_clk, i_rst_n, r_state == S_FINISH,
        o_strobe && o_result.last)
    // Only a report in progress produces results that are not final.
    `ATT_ASSERT_IMP(a_partial_is_leak, i_clk, i_rst_n, o_strobe && !o_result.last,
        busy && (r_cmd.operation == OP_REPORT) && (o_result.status == ST_LEAK))
    // A walk that has begun keeps the block busy until its write-back.
    `ATT_ASSERT_NXT(a_walk_holds, i_clk, i_rst_n, r_state == S_SCAN,
        (r_state == S_SCAN) || (r_state == S_DRAIN))

endmodule

`default_nettype wire

// ----- test/allocation_tracker_table_tb.sv -----
// Self-checking testbench for the heap allocation tracker table.
`timescale 1ns / 100ps

// This testbench drives allocation, free and leak-report commands into the
// tracker and checks every result against a small model of the tracking table.
//
// A command transfer happens at a rising edge where start is high and busy is
// low. A result transfer happens at every rising edge where o_strobe is high.
// The receiver cannot hold results off, so all results are taken as they come.
// Inputs change on the falling edge. The monitor samples at the rising edge.
//
// The stimulus runs in these phases:
//   - Directed commands. These cover the null address, the all-ones and
//     single-bit addresses, reallocation of a live entry, a double free, the
//     revival of a freed entry, a free of an unknown address, the unused
//     operation code, and reports with and without leaks.
//   - Random traffic. Most of it uses a small pool of addresses, so that
//     allocations and frees keep finding entries that are already tracked.
//     The rest is reports and noise: unknown frees, stray allocs, ignored codes.
//   - A pause in which the sender waits until every expected result has
//     arrived.
//   - A fill phase. Every pool address is allocated, which fills the table.
//     A report then lists every entry as a leak, and a further allocation is
//     refused because the table is full.
//   - More random traffic. It starts with a long stretch with no sender gaps.
module allocation_tracker_table_tb;
    import att_pkg::*;

    localparam int          TABLE_DEPTH = 32;
    localparam int          CLK_PERIOD  = 12;
    localparam int          POOL_SIZE   = 40;
    // The longest correct quiet spell is one table walk plus a few sender gaps,
    // or the settling wait at the end. This limit is many times that.
    localparam int          STALL_LIMIT = 2000;
    localparam int          MAX_REPORTS = 40;
    // The package does not name the fourth operation code. The block ignores it.
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    // Tracks the table contents and holds the results still expected, in order.
    class t_heap_table_model;
        bit                entry_used  [TABLE_DEPTH];
        logic [ADDR_W-1:0] entry_addr  [TABLE_DEPTH];
        bit                entry_freed [TABLE_DEPTH];
        t_result           expected_results [$];
        int unsigned       mismatches;

        function int pending();
            return expected_results.size();
        endfunction

        function void queue_result(logic [3:0] status, logic [ADDR_W-1:0] addr, logic last);
            t_result r;
            r.status         = status;
            r.report_address = addr;
            r.last           = last;
            expected_results.push_back(r);
        endfunction

        function int find_entry(logic [ADDR_W-1:0] addr);
            int i;
            for (i = 0; i < TABLE_DEPTH; i++) begin
                if (entry_used[i] && entry_addr[i] == addr) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Updates the table for one accepted command and queues its results.
        function void note_command(t_cmd cmd);
            int idx;
            int i;
            int leaks;
            int emitted;
            case (cmd.operation)
                OP_ALLOC: begin
                    if (cmd.address == '0) begin
                        queue_result(ST_NULL_ALLOC, '0, 1'b1);
                    end else begin
                        idx = find_entry(cmd.address);
                        if (idx >= 0) begin
                            if (entry_freed[idx]) begin
                                entry_freed[idx] = 1'b0;
                                queue_result(ST_REVIVED, cmd.address, 1'b1);
                            end else begin
                                queue_result(ST_REALLOC_LIVE, cmd.address, 1'b1);
                            end
                        end else begin
                            // A new address takes the lowest free slot.
                            for (i = 0; i < TABLE_DEPTH && idx < 0; i++) begin
                                if (!entry_used[i]) begin
                                    idx = i;
                                end
                            end
                            if (idx < 0) begin
                                queue_result(ST_FULL, cmd.address, 1'b1);
                            end else begin
                                entry_used[idx]  = 1'b1;
                                entry_addr[idx]  = cmd.address;
                                entry_freed[idx] = 1'b0;
                                queue_result(ST_NEW, cmd.address, 1'b1);
                            end
                        end
                    end
                end
                OP_FREE: begin
                    idx = find_entry(cmd.address);
                    if (idx < 0) begin
                        queue_result(ST_UNKNOWN_FREE, cmd.address, 1'b1);
                    end else if (entry_freed[idx]) begin
                        queue_result(ST_DOUBLE_FREE, cmd.address, 1'b1);
                    end else begin
                        entry_freed[idx] = 1'b1;
                        queue_result(ST_FREED, cmd.address, 1'b1);
                    end
                end
                OP_REPORT: begin
                    leaks = 0;
                    for (i = 0; i < TABLE_DEPTH; i++) begin
                        if (entry_used[i] && !entry_freed[i]) begin
                            leaks++;
                        end
                    end
                    if (leaks > REPORT_CAP) begin
                        leaks = REPORT_CAP;
                    end
                    if (leaks == 0) begin
                        queue_result(ST_NO_LEAK, '0, 1'b1);
                    end else begin
                        emitted = 0;
                        for (i = 0; i < TABLE_DEPTH && emitted < leaks; i++) begin
                            if (entry_used[i] && !entry_freed[i]) begin
                                emitted++;
                                queue_result(ST_LEAK, entry_addr[i], emitted == leaks);
                            end
                        end
                    end
                end
                default: begin
                    // The unused code is dropped and leaves the table unchanged.
                end
            endcase
        endfunction

        function void note_mismatch(string field, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, actual %h %h %b",
                             $time, got.status, got.report_address, got.last);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.status != want.status) begin
                note_mismatch("status", ADDR_W'(want.status), ADDR_W'(got.status));
            end
            if (got.report_address != want.report_address) begin
                note_mismatch("report_address", want.report_address, got.report_address);
            end
            if (got.last != want.last) begin
                note_mismatch("last", ADDR_W'(want.last), ADDR_W'(got.last));
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    t_heap_table_model tracker = new();
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    bit                gaps_on;
    int                idle_cycles;

    allocation_tracker_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // The monitor runs at the rising edge. It sees busy as it was just
    // before the edge, the same value the block uses to accept a command.
    // The result is checked before the new command is noted. The results of a
    // command accepted now belong behind everything already queued.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                tracker.check_result(o_result);
            end
            if (start && !busy) begin
                tracker.note_command(i_cmd);
            end
            if (o_strobe || (start && !busy)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Watchdog. It ends the run if nothing is transferred for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("[allocation_tracker_table] ERROR");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] random_address();
        return {$urandom, $urandom};
    endfunction

    // Presents one command and holds it until the block takes it. With gaps
    // enabled, the sender may first idle at random.
    task automatic send_command(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
        t_cmd cmd;
        cmd.operation = op;
        cmd.address   = addr;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 18) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    // Drops start, then waits until every expected result has arrived. It then
    // waits for about one table walk more, so that nothing is still in flight.
    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
    endtask

    // Random traffic, mostly on the address pool. Ignored codes are sent as
    // well but do not count towards the number of commands.
    task automatic run_random_traffic(input int commands);
        int sent;
        int sel;
        sent = 0;
        while (sent < commands) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                send_command(OP_ALLOC, addr_pool[$urandom_range(POOL_SIZE - 1)]);
            end else if (sel < 75) begin
                send_command(OP_FREE, addr_pool[$urandom_range(POOL_SIZE - 1)]);
            end else if (sel < 83) begin
                // A report ignores its address, but the address bits still toggle.
                send_command(OP_REPORT, random_address());
            end else if (sel < 88) begin
                send_command(OP_UNUSED, random_address());
            end else if (sel < 96) begin
                send_command(OP_FREE, random_address());
            end else if (sel < 98) begin
                send_command(OP_ALLOC, '0);
            end else begin
                send_command(OP_ALLOC, random_address());
            end
            if (sel < 83 || sel >= 88) begin
                sent++;
            end
        end
    endtask

    initial begin
        int i;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        gaps_on     = 1'b1;

        // The pool begins with the extreme addresses. The rest are random and
        // non-zero.
        addr_pool[0] = '1;
        addr_pool[1] = 64'h1;
        addr_pool[2] = 64'h8000_0000_0000_0000;
        for (i = 3; i < POOL_SIZE; i++) begin
            do begin
                addr_pool[i] = random_address();
            end while (addr_pool[i] == '0);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands.
        send_command(OP_REPORT, '0);              // empty table, so no leak
        send_command(OP_ALLOC, '0);               // null allocation
        send_command(OP_FREE, '0);                // null is never stored
        send_command(OP_ALLOC, addr_pool[0]);     // new entry
        send_command(OP_ALLOC, addr_pool[0]);     // reallocated while live
        send_command(OP_FREE, addr_pool[0]);      // freed
        send_command(OP_FREE, addr_pool[0]);      // double free
        send_command(OP_ALLOC, addr_pool[0]);     // revived
        send_command(OP_ALLOC, addr_pool[1]);
        send_command(OP_ALLOC, addr_pool[2]);
        send_command(OP_FREE, 64'h5555_5555_5555_5555);
        send_command(OP_UNUSED, 64'hAAAA_AAAA_AAAA_AAAA);
        send_command(OP_FREE, addr_pool[1]);
        send_command(OP_REPORT, '1);              // two leaks
        send_command(OP_FREE, addr_pool[0]);
        send_command(OP_REPORT, 64'hAAAA_AAAA_AAAA_AAAA);

        run_random_traffic(250);

        // The sender holds off here until the block has delivered everything.
        wait_for_results();

        // Allocating every pool address fills the table with live entries.
        // The report then gives one leak per entry, and one more new address
        // is refused because the table is full.
        for (i = 0; i < POOL_SIZE; i++) begin
            send_command(OP_ALLOC, addr_pool[i]);
        end
        send_command(OP_REPORT, '0);
        send_command(OP_ALLOC, 64'h5555_5555_5555_5555);

        gaps_on = 1'b0;
        run_random_traffic(80);
        gaps_on = 1'b1;
        run_random_traffic(120);

        wait_for_results();

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("[allocation_tracker_table] OK");
        end else begin
            $display("[allocation_tracker_table] ERROR");
        end
        $finish;
    end

endmodule
